### rtl/core/miq_pkg.sv
package miq_pkg;

    // command codes carried on the mode field
    typedef enum logic [1:0] {
        MODE_APPEND = 2'd0,
        MODE_INSERT = 2'd1,
        MODE_POP    = 2'd2
    } mode_t;

    // result status codes
    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    // control sequencer states
    typedef enum logic {
        S_IDLE = 1'b0,
        S_MOVE = 1'b1
    } state_t;

    // fixed width of the identifier fields on the ports
    localparam int PORT_ID_W = 32;

endpackage

### rtl/core/miq_ram.sv
module miq_ram #(
    parameter int DEPTH  = 512,
    parameter int DATA_W = 32,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/middle_insert_queue_core.sv
// Queue of identifiers with append at tail, insert at middle and pop at head.
// Command channel: cmd_valid / cmd_ready carry mode and in_id. Result channel:
// result_valid / result_ready carry out_id, out_valid and status; every
// command transfer yields exactly one result transfer, in command order.
// The queue lives in two ring buffers (front half, back half) held in
// synchronous RAMs with a registered read; the front half keeps the same
// number of entries as the back half or one more.
// Timing: a push, an error or an unused mode has its result registered in the
// cycle after the command transfer. A successful pop, and an append that
// moves one entry across the halves, reads a RAM and writes the moved entry
// in a following move state, during which cmd_ready is low; a pop result is
// loaded in that move state. Other commands can be taken every cycle while the result channel is not stalled.
// Reset empties the queue at once (pointers and counts cleared); the RAMs
// are not cleared and no clearing pass is needed.
// A stalled receiver holds the result register; cmd_ready stays low while a
// result waits and is not being taken in the same cycle.
module middle_insert_queue_core #(
    parameter int CAPACITY = 1024,
    parameter int ID_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cmd_valid,
    output logic        cmd_ready,
    input  logic [1:0]  mode,
    input  logic [31:0] in_id,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [31:0] out_id,
    output logic        out_valid,
    output logic [1:0]  status
);

    localparam int HALF    = (CAPACITY + 1) / 2;
    localparam int AW      = (HALF > 1) ? $clog2(HALF) : 1;
    localparam int CW      = $clog2(HALF + 1);
    localparam int SW      = CW + 1;
    localparam int STORE_W = (ID_WIDTH < miq_pkg::PORT_ID_W) ? ID_WIDTH
                                                            : miq_pkg::PORT_ID_W;

    // ring pointer advance with wraparound
    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] a,
                                               input logic [CW-1:0] b);
        logic [SW-1:0] s;
        s = SW'(a) + SW'(b);
        if (s >= SW'(HALF))
        begin
            s = s - SW'(HALF);
        end
        return s[AW-1:0];
    endfunction

    miq_pkg::state_t  state_reg, state_next;
    logic [AW-1:0]    fh_reg, fh_next;
    logic [AW-1:0]    bh_reg, bh_next;
    logic [CW-1:0]    fc_reg, fc_next;
    logic [CW-1:0]    bc_reg, bc_next;
    logic [AW-1:0]    mvaddr_reg;
    logic             mv_reg;
    logic             pop_reg;

    logic             result_valid_reg;
    logic [31:0]      out_id_reg;
    logic             out_valid_reg;
    miq_pkg::status_t status_reg;

    logic             cmd_xfer;
    logic [SW-1:0]    total;
    logic             full;
    logic [STORE_W-1:0] id_masked;
    miq_pkg::mode_t   cmd_mode;

    miq_pkg::status_t d_status;
    logic             d_fwe;
    logic [AW-1:0]    d_fwaddr;
    logic             d_bwe;
    logic [AW-1:0]    d_bwaddr;
    logic             d_move;
    logic             d_pop;
    logic [AW-1:0]    d_mvaddr;
    logic [AW-1:0]    bh_dec;

    logic               f_we;
    logic [AW-1:0]      f_waddr;
    logic [STORE_W-1:0] f_wdata;
    logic [STORE_W-1:0] f_rdata;
    logic [STORE_W-1:0] b_rdata;

    assign cmd_xfer  = cmd_valid && cmd_ready;
    assign total     = SW'(fc_reg) + SW'(bc_reg);
    assign full      = (total >= SW'(CAPACITY));
    assign id_masked = in_id[STORE_W-1:0];
    assign cmd_mode  = miq_pkg::mode_t'(mode);
    assign bh_dec    = (bh_reg == '0) ? AW'(HALF - 1) : (bh_reg - AW'(1));

    // command decode: memory accesses and pointer updates
    always_comb
    begin
        d_status = miq_pkg::STATUS_OK;
        d_fwe    = 1'b0;
        d_fwaddr = ring_add(fh_reg, fc_reg);
        d_bwe    = 1'b0;
        d_bwaddr = ring_add(bh_reg, bc_reg);
        d_move   = 1'b0;
        d_pop    = 1'b0;
        d_mvaddr = ring_add(fh_reg, fc_reg);
        fh_next  = fh_reg;
        bh_next  = bh_reg;
        fc_next  = fc_reg;
        bc_next  = bc_reg;
        unique case (cmd_mode)
            miq_pkg::MODE_APPEND:
            begin
                if (full)
                begin
                    d_status = miq_pkg::STATUS_FULL;
                end
                else if (bc_reg == fc_reg)
                begin
                    if (bc_reg == '0)
                    begin
                        d_fwe   = 1'b1;
                        fc_next = fc_reg + CW'(1);
                    end
                    else
                    begin
                        // push at back tail, back head moves to front tail
                        d_bwe   = 1'b1;
                        d_move  = 1'b1;
                        bh_next = ring_add(bh_reg, CW'(1));
                        fc_next = fc_reg + CW'(1);
                    end
                end
                else
                begin
                    d_bwe   = 1'b1;
                    bc_next = bc_reg + CW'(1);
                end
            end
            miq_pkg::MODE_INSERT:
            begin
                if (full)
                begin
                    d_status = miq_pkg::STATUS_FULL;
                end
                else if (fc_reg > bc_reg)
                begin
                    d_bwe    = 1'b1;
                    d_bwaddr = bh_dec;
                    bh_next  = bh_dec;
                    bc_next  = bc_reg + CW'(1);
                end
                else
                begin
                    d_fwe   = 1'b1;
                    fc_next = fc_reg + CW'(1);
                end
            end
            miq_pkg::MODE_POP:
            begin
                if (fc_reg == '0)
                begin
                    d_status = miq_pkg::STATUS_EMPTY;
                end
                else
                begin
                    d_pop   = 1'b1;
                    fh_next = ring_add(fh_reg, CW'(1));
                    if (bc_reg == fc_reg)
                    begin
                        d_move  = 1'b1;
                        bh_next = ring_add(bh_reg, CW'(1));
                        bc_next = bc_reg - CW'(1);
                    end
                    else
                    begin
                        fc_next = fc_reg - CW'(1);
                    end
                end
            end
            default:
            begin
                d_status = miq_pkg::STATUS_OK;
            end
        endcase
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            miq_pkg::S_IDLE:
            begin
                if (cmd_xfer && (d_move || d_pop))
                begin
                    state_next = miq_pkg::S_MOVE;
                end
            end
            miq_pkg::S_MOVE:
            begin
                state_next = miq_pkg::S_IDLE;
            end
            default:
            begin
                state_next = miq_pkg::S_IDLE;
            end
        endcase
    end

    // sequencer outputs: command ready and front write port
    always_comb
    begin
        cmd_ready = 1'b0;
        f_we      = 1'b0;
        f_waddr   = d_fwaddr;
        f_wdata   = id_masked;
        unique case (state_reg)
            miq_pkg::S_IDLE:
            begin
                cmd_ready = !result_valid_reg || result_ready;
                f_we      = cmd_xfer && d_fwe;
            end
            miq_pkg::S_MOVE:
            begin
                f_we    = mv_reg;
                f_waddr = mvaddr_reg;
                f_wdata = b_rdata;
            end
            default:
            begin
                cmd_ready = 1'b0;
            end
        endcase
    end

    // front half ring storage
    miq_ram #(
        .DEPTH  (HALF),
        .DATA_W (STORE_W),
        .ADDR_W (AW)
    ) u_front_ram (
        .clk   (clk),
        .we    (f_we),
        .waddr (f_waddr),
        .wdata (f_wdata),
        .re    (cmd_xfer),
        .raddr (fh_reg),
        .rdata (f_rdata)
    );

    // back half ring storage
    miq_ram #(
        .DEPTH  (HALF),
        .DATA_W (STORE_W),
        .ADDR_W (AW)
    ) u_back_ram (
        .clk   (clk),
        .we    (cmd_xfer && d_bwe),
        .waddr (d_bwaddr),
        .wdata (id_masked),
        .re    (cmd_xfer),
        .raddr (bh_reg),
        .rdata (b_rdata)
    );

    // control state and ring pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= miq_pkg::S_IDLE;
            fh_reg    <= '0;
            bh_reg    <= '0;
            fc_reg    <= '0;
            bc_reg    <= '0;
            mv_reg    <= 1'b0;
            pop_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd_xfer)
            begin
                fh_reg  <= fh_next;
                bh_reg  <= bh_next;
                fc_reg  <= fc_next;
                bc_reg  <= bc_next;
                mv_reg  <= d_move;
                pop_reg <= d_pop;
            end
        end
    end

    // move target address for the move state
    always_ff @(posedge clk)
    begin
        if (cmd_xfer)
        begin
            mvaddr_reg <= d_mvaddr;
        end
    end

    // result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if ((cmd_xfer && !d_pop) || (state_reg == miq_pkg::S_MOVE && pop_reg))
        begin
            result_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (state_reg == miq_pkg::S_MOVE && pop_reg)
        begin
            out_id_reg    <= 32'(f_rdata);
            out_valid_reg <= 1'b1;
            status_reg    <= miq_pkg::STATUS_OK;
        end
        else if (cmd_xfer && !d_pop)
        begin
            out_id_reg    <= '0;
            out_valid_reg <= 1'b0;
            status_reg    <= d_status;
        end
    end

    assign result_valid = result_valid_reg;
    assign out_id       = out_id_reg;
    assign out_valid    = out_valid_reg;
    assign status       = status_reg;

    // halves stay balanced
    assert property (@(posedge clk) disable iff (!rst_n)
        (fc_reg == bc_reg) || (SW'(fc_reg) == SW'(bc_reg) + SW'(1)))
        else $error("queue halves out of balance");

    // occupancy never exceeds capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        total <= SW'(CAPACITY))
        else $error("queue occupancy above capacity");

    // the move state always returns to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == miq_pkg::S_MOVE |=> state_reg == miq_pkg::S_IDLE)
        else $error("move cycle did not return to idle");

    // a popped identifier always comes with ok status
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid_reg && out_valid_reg) |-> status_reg == miq_pkg::STATUS_OK)
        else $error("popped identifier with error status");

    // a successful pop has its result ready after the move cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == miq_pkg::S_MOVE && pop_reg) |=> (result_valid_reg && out_valid_reg))
        else $error("pop result not loaded");

endmodule
